// ===== rtl/msadpcm_pkg.sv =====
// Package for the MS-ADPCM block decoder: shared types, constants and tables.
// Used by msadpcm_dp and ms_adpcm_block_decoder in rtl/; depends on nothing else.
package msadpcm_pkg;

    // Top-level sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_PUSH,
        ST_HDR
    } state_t;

    // Operation of the shared multiply datapath in the current cycle.
    typedef enum logic [2:0] {
        OP_NONE,
        OP_MUL1,
        OP_MUL2,
        OP_MUL3,
        OP_MUL4,
        OP_FIN
    } dp_op_t;

    // Header field that the current header byte lands in.
    typedef enum logic [2:0] {
        FLD_NONE,
        FLD_PRED,
        FLD_STEP,
        FLD_NEWEST,
        FLD_OLDER
    } hdr_fld_t;

    // Control bundle from the sequencer to the datapath.
    typedef struct packed {
        dp_op_t     op;
        logic [3:0] code;
    } dp_ctrl_t;

    // Configuration register indexes.
    localparam logic CFG_CHANNEL_COUNT = 1'b0;
    localparam logic CFG_BLOCK_BYTES   = 1'b1;

    localparam logic [1:0]  CHANNEL_COUNT_RESET = 2'd2;
    localparam logic [1:0]  CHANNEL_COUNT_MONO  = 2'd1;
    localparam logic [12:0] BLOCK_BYTES_RESET   = 13'd1024;

    localparam logic [3:0] MONO_HDR_LEN   = 4'd7;
    localparam logic [3:0] STEREO_HDR_LEN = 4'd14;

    localparam int BUILTIN_PAIRS = 7;

    localparam logic signed [31:0] STEP_FLOOR = 32'sd16;
    localparam logic signed [31:0] STEP_CEIL  = 32'sd32767;
    localparam logic signed [33:0] SAMPLE_MAX = 34'sd32767;
    localparam logic signed [33:0] SAMPLE_MIN = -34'sd32768;
    localparam logic [3:0]         NIBBLE_MASK = 4'hF;

    // Step adaptation factor for a 4-bit code, scaled by 256.
    function automatic logic signed [15:0] adapt_factor(input logic [3:0] code);
        logic signed [15:0] f;
        case (code & NIBBLE_MASK)
            4'd4, 4'd12:                      f = 16'sd307;
            4'd5, 4'd11:                      f = 16'sd409;
            4'd6, 4'd10:                      f = 16'sd512;
            4'd7, 4'd9:                       f = 16'sd614;
            4'd8:                             f = 16'sd768;
            default:                          f = 16'sd230;
        endcase
        return f;
    endfunction

    // Built-in weight of the newest sample for a table entry.
    function automatic logic signed [15:0] builtin_first(input int idx);
        logic signed [15:0] c;
        case (idx)
            0:       c = 16'sd256;
            1:       c = 16'sd512;
            3:       c = 16'sd192;
            4:       c = 16'sd240;
            5:       c = 16'sd460;
            6:       c = 16'sd392;
            default: c = 16'sd0;
        endcase
        return c;
    endfunction

    // Built-in weight of the older sample for a table entry.
    function automatic logic signed [15:0] builtin_second(input int idx);
        logic signed [15:0] c;
        case (idx)
            1:       c = -16'sd256;
            3:       c = 16'sd64;
            5:       c = -16'sd208;
            6:       c = -16'sd232;
            default: c = 16'sd0;
        endcase
        return c;
    endfunction

endpackage

// ===== rtl/msadpcm_mult.sv =====
// Shared 16x16 signed multiplier with a registered product.
// Depends on nothing; instantiated by msadpcm_dp.
module msadpcm_mult (
    input  logic               aclk,
    input  logic               en,
    input  logic signed [15:0] a,
    input  logic signed [15:0] b,
    output logic signed [31:0] prod
);

    logic signed [31:0] prod_reg;

    // Capture the product only when the sequencer issues a multiply.
    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= a * b;
        end
    end

    assign prod = prod_reg;

endmodule

// ===== rtl/msadpcm_dp.sv =====
// Nibble datapath: operand selection, accumulator, saturation and step update.
// Depends on msadpcm_pkg and msadpcm_mult.
module msadpcm_dp
    import msadpcm_pkg::*;
(
    input  logic               aclk,
    input  dp_ctrl_t           ctrl,
    input  logic signed [15:0] newest,
    input  logic signed [15:0] older,
    input  logic signed [15:0] coef_first,
    input  logic signed [15:0] coef_second,
    input  logic signed [15:0] step,
    output logic signed [15:0] sample,
    output logic [15:0]        new_step
);

    logic signed [15:0] mul_a;
    logic signed [15:0] mul_b;
    logic               mul_en;
    logic signed [31:0] prod;
    logic signed [32:0] acc_reg;
    logic signed [32:0] pred;
    logic signed [33:0] cur;
    logic signed [15:0] sample_reg;
    logic signed [31:0] scaled_step;

    // Operand selection for the shared multiplier, one product per step.
    always_comb begin
        mul_a  = 16'sd0;
        mul_b  = 16'sd0;
        mul_en = 1'b0;
        case (ctrl.op)
            OP_MUL1: begin
                mul_a  = newest;
                mul_b  = coef_first;
                mul_en = 1'b1;
            end
            OP_MUL2: begin
                mul_a  = older;
                mul_b  = coef_second;
                mul_en = 1'b1;
            end
            OP_MUL3: begin
                mul_a  = 16'(signed'(ctrl.code));
                mul_b  = step;
                mul_en = 1'b1;
            end
            OP_MUL4: begin
                mul_a  = adapt_factor(ctrl.code);
                mul_b  = step;
                mul_en = 1'b1;
            end
            default: begin
                mul_en = 1'b0;
            end
        endcase
    end

    msadpcm_mult u_mult (
        .aclk (aclk),
        .en   (mul_en),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    // Prediction with floor division by 256, plus the scaled code.
    assign pred = acc_reg >>> 8;
    assign cur  = 34'(pred) + 34'(prod);

    // Accumulate the two prediction terms, then form the saturated sample.
    always_ff @(posedge aclk) begin
        case (ctrl.op)
            OP_MUL2: begin
                acc_reg <= 33'(prod);
            end
            OP_MUL3: begin
                acc_reg <= acc_reg + 33'(prod);
            end
            OP_MUL4: begin
                if (cur > SAMPLE_MAX) begin
                    sample_reg <= 16'sd32767;
                end else if (cur < SAMPLE_MIN) begin
                    sample_reg <= -16'sd32768;
                end else begin
                    sample_reg <= cur[15:0];
                end
            end
            default: begin
                acc_reg <= acc_reg;
            end
        endcase
    end

    // Adapted step, clamped to the legal range; valid in the final step.
    assign scaled_step = prod >>> 8;

    always_comb begin
        if (scaled_step < STEP_FLOOR) begin
            new_step = 16'd16;
        end else if (scaled_step > STEP_CEIL) begin
            new_step = 16'd32767;
        end else begin
            new_step = scaled_step[15:0];
        end
    end

    assign sample = sample_reg;

endmodule

// ===== rtl/ms_adpcm_block_decoder.sv =====
// Top level of the MS-ADPCM block decoder: APB registers, header parsing,
// channel state, sequencer and output register. Depends on msadpcm_pkg, msadpcm_dp.
//
// Channel   Handshake          Payload
// s_        s_valid/s_ready    s_action, s_data_byte, s_coef_index, s_coef_first,
//                              s_coef_second
// m_        m_valid/m_ready    m_sample, m_channel, m_last
// APB       psel/penable/      pwrite, paddr, pwdata, prdata, pready (always high)
//
// The final header byte is followed by one output per header sample (two mono,
// four stereo). Each nibble of a data byte takes four passes through the one
// shared multiplier, a step update and an output. s_ready stays low until the
// sequencer is back in idle. A stalled m_ready holds the sequencer before each
// output. Reset is synchronous and restores the built-in table.
module ms_adpcm_block_decoder
    import msadpcm_pkg::*;
#(
    parameter int COEF_ENTRIES = 8
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_action,
    input  logic [7:0]         s_data_byte,
    input  logic [2:0]         s_coef_index,
    input  logic signed [15:0] s_coef_first,
    input  logic signed [15:0] s_coef_second,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_sample,
    output logic               m_channel,
    output logic               m_last,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    // Only entries reachable by a 3-bit load index need storage.
    localparam int TBL_N   = (COEF_ENTRIES < 8) ? COEF_ENTRIES : 8;
    localparam int TIDX_W  = $clog2(TBL_N);
    localparam int PRED_W  = $clog2(COEF_ENTRIES);

    state_t state_reg, state_next;
    dp_op_t op_reg, op_next;

    logic [1:0]  cc_reg;
    logic [12:0] bb_reg;
    logic [12:0] pos_reg;
    logic [7:0]  byte_reg;
    logic        nib_sel_reg;
    logic [1:0]  hdr_idx_reg;

    logic signed [15:0] c1_reg [TBL_N];
    logic signed [15:0] c2_reg [TBL_N];

    logic [15:0]       step_reg   [2];
    logic [15:0]       newest_reg [2];
    logic [15:0]       older_reg  [2];
    logic [PRED_W-1:0] pred_reg   [2];

    logic               m_valid_reg;
    logic signed [15:0] m_sample_reg;
    logic               m_channel_reg;
    logic               m_last_reg;

    logic        accept;
    logic        cfg_wr;
    logic        mono;
    logic [3:0]  hlen;
    logic [12:0] blen;
    logic        in_hdr;
    logic        hdr_end;
    logic [13:0] pos_inc;
    logic [12:0] pos_next;
    logic        slot_free;
    logic        load_out;
    logic        cur_ch;
    logic        hdr_last;
    logic        hdr_ch;
    logic        hdr_sel_newest;
    logic        wb;

    hdr_fld_t    fld;
    logic        fld_ch;
    logic        fld_hi;
    logic [3:0]  hp;
    logic [3:0]  hr;
    logic [PRED_W-1:0] pred_val;

    logic [PRED_W-1:0]  cur_pred;
    logic               coef_hit;
    logic signed [15:0] cur_c1;
    logic signed [15:0] cur_c2;

    dp_ctrl_t           dp_ctrl;
    logic signed [15:0] dp_sample;
    logic [15:0]        dp_new_step;

    // Handshake and configuration decode.
    assign accept    = s_valid && s_ready;
    assign cfg_wr    = psel && penable && pwrite && pready;
    assign pready    = 1'b1;
    assign slot_free = !m_valid_reg || m_ready;

    always_comb begin
        case (paddr[2])
            CFG_CHANNEL_COUNT: prdata = {30'd0, cc_reg};
            CFG_BLOCK_BYTES:   prdata = {19'd0, bb_reg};
            default:           prdata = 32'd0;
        endcase
    end

    // Block geometry and position advance.
    assign mono     = (cc_reg == CHANNEL_COUNT_MONO);
    assign hlen     = mono ? MONO_HDR_LEN : STEREO_HDR_LEN;
    assign blen     = (bb_reg < 13'(hlen)) ? 13'(hlen) : bb_reg;
    assign in_hdr   = pos_reg < 13'(hlen);
    assign hdr_end  = pos_reg == 13'(hlen - 4'd1);
    assign pos_inc  = {1'b0, pos_reg} + 14'd1;
    assign pos_next = (pos_inc >= {1'b0, blen}) ? 13'd0 : pos_inc[12:0];

    // Map the header byte position to a field, channel and byte half.
    assign hp = pos_reg[3:0];
    assign hr = hp - 4'd2;
    assign pred_val = ({1'b0, s_data_byte} < 9'(COEF_ENTRIES)) ?
                      s_data_byte[PRED_W-1:0] : '0;

    always_comb begin
        fld    = FLD_NONE;
        fld_ch = 1'b0;
        fld_hi = 1'b0;
        if (mono) begin
            case (hp)
                4'd0:       fld = FLD_PRED;
                4'd1, 4'd2: fld = FLD_STEP;
                4'd3, 4'd4: fld = FLD_NEWEST;
                4'd5, 4'd6: fld = FLD_OLDER;
                default:    fld = FLD_NONE;
            endcase
            fld_hi = (hp == 4'd2) || (hp == 4'd4) || (hp == 4'd6);
        end else if (hp < 4'd2) begin
            fld    = FLD_PRED;
            fld_ch = hp[0];
        end else begin
            fld_ch = hr[1];
            fld_hi = hr[0];
            if (hr < 4'd4) begin
                fld = FLD_STEP;
            end else if (hr < 4'd8) begin
                fld = FLD_NEWEST;
            end else begin
                fld = FLD_OLDER;
            end
        end
    end

    // Header sample emission order: older then newest, left before right.
    assign hdr_ch         = mono ? 1'b0 : hdr_idx_reg[0];
    assign hdr_sel_newest = mono ? hdr_idx_reg[0] : hdr_idx_reg[1];
    assign hdr_last       = mono ? (hdr_idx_reg == 2'd1) : (hdr_idx_reg == 2'd3);

    // Current nibble's channel and its coefficient pair.
    assign cur_ch   = nib_sel_reg && !mono;
    assign cur_pred = pred_reg[cur_ch];
    assign coef_hit = 9'(cur_pred) < 9'(TBL_N);
    assign cur_c1   = coef_hit ? c1_reg[cur_pred[TIDX_W-1:0]] : 16'sd0;
    assign cur_c2   = coef_hit ? c2_reg[cur_pred[TIDX_W-1:0]] : 16'sd0;

    assign dp_ctrl.op   = (state_reg == ST_CALC) ? op_reg : OP_NONE;
    assign dp_ctrl.code = nib_sel_reg ? byte_reg[3:0] : byte_reg[7:4];

    msadpcm_dp u_dp (
        .aclk        (aclk),
        .ctrl        (dp_ctrl),
        .newest      (signed'(newest_reg[cur_ch])),
        .older       (signed'(older_reg[cur_ch])),
        .coef_first  (cur_c1),
        .coef_second (cur_c2),
        .step        (signed'(step_reg[cur_ch])),
        .sample      (dp_sample),
        .new_step    (dp_new_step)
    );

    // Next-state logic of the sequencer.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept && !s_action) begin
                    if (!in_hdr) begin
                        state_next = ST_CALC;
                    end else if (hdr_end) begin
                        state_next = ST_HDR;
                    end
                end
            end
            ST_CALC: begin
                if (op_reg == OP_FIN) begin
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH: begin
                if (slot_free) begin
                    state_next = nib_sel_reg ? ST_IDLE : ST_CALC;
                end
            end
            ST_HDR: begin
                if (slot_free && hdr_last) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output logic of the sequencer.
    always_comb begin
        s_ready  = 1'b0;
        load_out = 1'b0;
        wb       = 1'b0;
        op_next  = OP_NONE;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                op_next = OP_MUL1;
            end
            ST_CALC: begin
                wb = (op_reg == OP_FIN);
                case (op_reg)
                    OP_MUL1: op_next = OP_MUL2;
                    OP_MUL2: op_next = OP_MUL3;
                    OP_MUL3: op_next = OP_MUL4;
                    OP_MUL4: op_next = OP_FIN;
                    default: op_next = OP_NONE;
                endcase
            end
            ST_PUSH: begin
                load_out = slot_free;
                op_next  = OP_MUL1;
            end
            ST_HDR: begin
                load_out = slot_free;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    // Sequencer registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            op_reg      <= OP_NONE;
            nib_sel_reg <= 1'b0;
            hdr_idx_reg <= 2'd0;
            pos_reg     <= 13'd0;
        end else begin
            state_reg <= state_next;
            op_reg    <= op_next;
            if (accept) begin
                nib_sel_reg <= 1'b0;
                hdr_idx_reg <= 2'd0;
                if (!s_action) begin
                    pos_reg <= pos_next;
                end
            end else begin
                if (state_reg == ST_PUSH && slot_free) begin
                    nib_sel_reg <= 1'b1;
                end
                if (state_reg == ST_HDR && slot_free) begin
                    hdr_idx_reg <= hdr_idx_reg + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            byte_reg <= s_data_byte;
        end
    end

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cc_reg <= CHANNEL_COUNT_RESET;
            bb_reg <= BLOCK_BYTES_RESET;
        end else if (cfg_wr) begin
            case (paddr[2])
                CFG_CHANNEL_COUNT: cc_reg <= pwdata[1:0];
                CFG_BLOCK_BYTES:   bb_reg <= pwdata[12:0];
                default:           cc_reg <= cc_reg;
            endcase
        end
    end

    // Coefficient table, loaded by a table transaction.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < TBL_N; i++) begin
                c1_reg[i] <= (i < BUILTIN_PAIRS) ? builtin_first(i) : 16'sd0;
                c2_reg[i] <= (i < BUILTIN_PAIRS) ? builtin_second(i) : 16'sd0;
            end
        end else if (accept && s_action && (4'(s_coef_index) < 4'(TBL_N))) begin
            c1_reg[s_coef_index[TIDX_W-1:0]] <= s_coef_first;
            c2_reg[s_coef_index[TIDX_W-1:0]] <= s_coef_second;
        end
    end

    // Per-channel decoder state: header byte writes and nibble write-back.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 2; i++) begin
                step_reg[i]   <= 16'd0;
                newest_reg[i] <= 16'd0;
                older_reg[i]  <= 16'd0;
                pred_reg[i]   <= '0;
            end
        end else if (accept && !s_action && in_hdr) begin
            case (fld)
                FLD_PRED: begin
                    pred_reg[fld_ch] <= pred_val;
                end
                FLD_STEP: begin
                    if (fld_hi) step_reg[fld_ch][15:8] <= s_data_byte;
                    else        step_reg[fld_ch][7:0]  <= s_data_byte;
                end
                FLD_NEWEST: begin
                    if (fld_hi) newest_reg[fld_ch][15:8] <= s_data_byte;
                    else        newest_reg[fld_ch][7:0]  <= s_data_byte;
                end
                FLD_OLDER: begin
                    if (fld_hi) older_reg[fld_ch][15:8] <= s_data_byte;
                    else        older_reg[fld_ch][7:0]  <= s_data_byte;
                end
                default: begin
                    pred_reg[0] <= pred_reg[0];
                end
            endcase
        end else if (wb) begin
            step_reg[cur_ch]   <= dp_new_step;
            older_reg[cur_ch]  <= newest_reg[cur_ch];
            newest_reg[cur_ch] <= dp_sample;
        end
    end

    // Output register: holds one result while the sequencer moves on.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            if (state_reg == ST_HDR) begin
                m_sample_reg  <= hdr_sel_newest ? signed'(newest_reg[hdr_ch]) :
                                                  signed'(older_reg[hdr_ch]);
                m_channel_reg <= hdr_ch;
                m_last_reg    <= hdr_last;
            end else begin
                m_sample_reg  <= dp_sample;
                m_channel_reg <= cur_ch;
                m_last_reg    <= nib_sel_reg;
            end
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_sample  = m_sample_reg;
    assign m_channel = m_channel_reg;
    assign m_last    = m_last_reg;

    // A data byte past the header starts the multiply sequence.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !s_action && !in_hdr) |=> (state_reg == ST_CALC && op_reg == OP_MUL1))
        else $error("data transaction did not start the nibble sequence");

    // A new result never overwrites one that is still waiting.
    assert property (@(posedge aclk) disable iff (!aresetn)
        load_out |-> (!m_valid_reg || m_ready))
        else $error("output register overwritten while stalled");

    // The last header sample carries the last flag.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_HDR && slot_free && hdr_last) |=> (m_valid && m_last))
        else $error("final header sample missing its last flag");

endmodule

// ===== sim/ms_adpcm_block_decoder_tb.sv =====
// Self-checking testbench for the MS-ADPCM block decoder.
// Depends on msadpcm_pkg and ms_adpcm_block_decoder from rtl/; needs nothing else.
`timescale 1ns / 1ps

module ms_adpcm_block_decoder_tb
    import msadpcm_pkg::*;
();

    localparam int COEF_ENTRIES   = 8;
    localparam int TX_BUSY_PCT    = 38;
    localparam int RX_BUSY_PCT    = 78;
    localparam int SETTLE_CYCLES  = 40;
    localparam int DRAIN_LIMIT    = 20000;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int TIMEOUT_NS     = 5_000_000;

    // Step adaptation factors and built-in predictor weights, all scaled by 256.
    localparam int ADAPT_GAIN[16] = '{230, 230, 230, 230, 307, 409, 512, 614,
                                      768, 614, 512, 409, 307, 230, 230, 230};
    localparam int DEFAULT_FIRST[7]  = '{256, 512, 0, 192, 240, 460, 392};
    localparam int DEFAULT_SECOND[7] = '{0, -256, 0, 64, 0, -208, -232};

    // One input transaction: a stream byte or a coefficient load.
    typedef struct {
        bit                 act;
        logic [7:0]         b;
        logic [2:0]         idx;
        logic signed [15:0] first;
        logic signed [15:0] second;
    } stim_t;

    typedef struct {
        logic signed [15:0] sample;
        bit                 channel;
        bit                 last;
    } sample_t;

    // Decoder state mirror plus the queue of samples still owed by the block.
    class sample_scoreboard;
        logic [1:0]         channel_count;
        logic [12:0]        block_bytes;
        logic signed [15:0] coef_first[COEF_ENTRIES];
        logic signed [15:0] coef_second[COEF_ENTRIES];
        logic [15:0]        step[2];
        logic [15:0]        newest[2];
        logic [15:0]        older[2];
        int unsigned        pred_sel[2];
        int unsigned        byte_pos;
        sample_t            pending_samples[$];
        int                 error_count;
        int                 samples_checked;
        int                 bytes_fed;
        int                 loads_fed;

        function new();
            channel_count = CHANNEL_COUNT_RESET;
            block_bytes = BLOCK_BYTES_RESET;
            for (int i = 0; i < COEF_ENTRIES; i++) begin
                coef_first[i]  = (i < 7) ? 16'(DEFAULT_FIRST[i]) : 16'sd0;
                coef_second[i] = (i < 7) ? 16'(DEFAULT_SECOND[i]) : 16'sd0;
            end
            for (int c = 0; c < 2; c++) begin
                step[c] = '0;
                newest[c] = '0;
                older[c] = '0;
                pred_sel[c] = 0;
            end
            byte_pos = 0;
            error_count = 0;
            samples_checked = 0;
            bytes_fed = 0;
            loads_fed = 0;
        endfunction

        function bit is_mono();
            return channel_count == CHANNEL_COUNT_MONO;
        endfunction

        function int unsigned header_len();
            return is_mono() ? int'(MONO_HDR_LEN) : int'(STEREO_HDR_LEN);
        endfunction

        // Which header field the next stream byte lands in, with its byte half and channel.
        function hdr_fld_t header_field(output bit hi, output bit ch);
            int unsigned r;
            hi = 1'b0;
            ch = 1'b0;
            if (byte_pos >= header_len())
                return FLD_NONE;
            if (is_mono()) begin
                if (byte_pos == 0)
                    return FLD_PRED;
                hi = (byte_pos % 2) == 0;
                if (byte_pos <= 2)
                    return FLD_STEP;
                if (byte_pos <= 4)
                    return FLD_NEWEST;
                return FLD_OLDER;
            end
            if (byte_pos < 2) begin
                ch = byte_pos[0];
                return FLD_PRED;
            end
            r = byte_pos - 2;
            ch = r[1];
            hi = r[0];
            if (r < 4)
                return FLD_STEP;
            if (r < 8)
                return FLD_NEWEST;
            return FLD_OLDER;
        endfunction

        function logic [15:0] with_byte(logic [15:0] r, bit hi, logic [7:0] b);
            return hi ? {b, r[7:0]} : {r[15:8], b};
        endfunction

        function void push_sample(logic signed [15:0] s, bit ch, bit last);
            sample_t e;
            e.sample = s;
            e.channel = ch;
            e.last = last;
            pending_samples.push_back(e);
        endfunction

        // Decode one 4-bit code on a channel and adapt that channel's step.
        function logic signed [15:0] predict_nibble(bit ch, logic [3:0] code);
            int unsigned p;
            longint      c1, c2, stp, guess, cur, nstep;
            p = pred_sel[ch];
            if (p >= COEF_ENTRIES)
                p = 0;
            c1 = coef_first[p];
            c2 = coef_second[p];
            stp = longint'($signed(step[ch]));
            guess = (longint'($signed(newest[ch])) * c1 +
                     longint'($signed(older[ch])) * c2) >>> 8;
            cur = guess + longint'($signed(code)) * stp;
            if (cur > 32767)
                cur = 32767;
            if (cur < -32768)
                cur = -32768;
            nstep = (longint'(ADAPT_GAIN[code]) * stp) >>> 8;
            if (nstep < 16)
                nstep = 16;
            if (nstep > 32767)
                nstep = 32767;
            step[ch] = nstep[15:0];
            older[ch] = newest[ch];
            newest[ch] = cur[15:0];
            return cur[15:0];
        endfunction

        // Called for every accepted input transaction.
        function void accept_item(stim_t it);
            hdr_fld_t    fld;
            bit          hi, ch, mono;
            int unsigned blen, pos;
            if (it.act) begin
                if (it.idx < COEF_ENTRIES) begin
                    coef_first[it.idx] = it.first;
                    coef_second[it.idx] = it.second;
                end
                loads_fed++;
                return;
            end
            bytes_fed++;
            mono = is_mono();
            blen = (block_bytes < header_len()) ? header_len() : block_bytes;
            fld = header_field(hi, ch);
            case (fld)
                FLD_PRED:   pred_sel[ch] = (it.b < COEF_ENTRIES) ? it.b : 0;
                FLD_STEP:   step[ch] = with_byte(step[ch], hi, it.b);
                FLD_NEWEST: newest[ch] = with_byte(newest[ch], hi, it.b);
                FLD_OLDER:  older[ch] = with_byte(older[ch], hi, it.b);
                default: begin
                    push_sample(predict_nibble(1'b0, it.b[7:4]), 1'b0, 1'b0);
                    push_sample(predict_nibble(!mono, it.b[3:0]), !mono, 1'b1);
                end
            endcase
            // The last header byte releases the header samples, older ones first.
            if (fld != FLD_NONE && byte_pos == header_len() - 1) begin
                push_sample(older[0], 1'b0, 1'b0);
                if (!mono)
                    push_sample(older[1], 1'b1, 1'b0);
                push_sample(newest[0], 1'b0, mono);
                if (!mono)
                    push_sample(newest[1], 1'b1, 1'b1);
            end
            pos = byte_pos + 1;
            byte_pos = (pos >= blen) ? 0 : (pos & 32'h1FFF);
        endfunction

        // Called for every accepted result transaction.
        function void check_sample(logic signed [15:0] s, logic ch, logic last);
            sample_t e;
            if (pending_samples.size() == 0) begin
                $error("unexpected sample %0d on channel %0d", s, ch);
                error_count++;
                return;
            end
            e = pending_samples.pop_front();
            samples_checked++;
            if (s !== e.sample) begin
                $error("sample: expected %0d, got %0d", e.sample, s);
                error_count++;
            end
            if (ch !== e.channel) begin
                $error("channel: expected %0d, got %0d", e.channel, ch);
                error_count++;
            end
            if (last !== e.last) begin
                $error("last: expected %0d, got %0d", e.last, last);
                error_count++;
            end
        endfunction
    endclass

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic               s_action;
    logic [7:0]         s_data_byte;
    logic [2:0]         s_coef_index;
    logic signed [15:0] s_coef_first;
    logic signed [15:0] s_coef_second;
    logic               m_valid;
    logic               m_ready;
    logic signed [15:0] m_sample;
    logic               m_channel;
    logic               m_last;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [2:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    sample_scoreboard sb;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    bit rx_hold_armed = 1'b0;
    int settings_used = 0;

    ms_adpcm_block_decoder #(
        .COEF_ENTRIES(COEF_ENTRIES)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_action(s_action),
        .s_data_byte(s_data_byte),
        .s_coef_index(s_coef_index),
        .s_coef_first(s_coef_first),
        .s_coef_second(s_coef_second),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_sample(m_sample),
        .m_channel(m_channel),
        .m_last(m_last),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    // 10 ns clock.
    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Receiver: random back-pressure, plus one long hold once it is armed.
    initial begin : rx_ready_gen
        int held;
        held = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (rx_hold_armed && held < RX_HOLD_CYCLES) begin
                m_ready <= 1'b0;
                held++;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    // Every result transaction is checked against the oldest expected sample.
    always @(posedge aclk) begin
        if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready === 1'b1)
            sb.check_sample(m_sample, m_channel, m_last);
    end

    function automatic stim_t feed(logic [7:0] b);
        stim_t it;
        it.act = 1'b0;
        it.b = b;
        it.idx = 3'($urandom_range(0, 7));
        it.first = 16'($urandom);
        it.second = 16'($urandom);
        return it;
    endfunction

    function automatic stim_t load(logic [2:0] idx, logic signed [15:0] f,
                                   logic signed [15:0] s);
        stim_t it;
        it.act = 1'b1;
        it.b = 8'($urandom);
        it.idx = idx;
        it.first = f;
        it.second = s;
        return it;
    endfunction

    // Mostly well-formed blocks: sane predictor indexes and moderate steps, rare loads.
    function automatic stim_t random_item();
        stim_t    it;
        hdr_fld_t fld;
        bit       hi, ch;
        if ($urandom_range(0, 99) < 4) begin
            if ($urandom_range(0, 99) < 80)
                it = load(3'($urandom_range(0, 7)), 16'($urandom_range(0, 1024)) - 16'sd512,
                          16'($urandom_range(0, 1024)) - 16'sd512);
            else
                it = load(3'($urandom_range(0, 7)), 16'($urandom), 16'($urandom));
            return it;
        end
        it = feed(8'($urandom));
        fld = sb.header_field(hi, ch);
        if (fld == FLD_PRED && $urandom_range(0, 99) < 90)
            it.b = 8'($urandom_range(0, 7));
        if (fld == FLD_STEP && hi && $urandom_range(0, 99) < 75)
            it.b = 8'($urandom_range(0, 3));
        return it;
    endfunction

    // Offer one input transaction and hold it until the block takes it.
    task automatic send_item(stim_t it);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_action <= it.act;
        s_data_byte <= it.b;
        s_coef_index <= it.idx;
        s_coef_first <= it.first;
        s_coef_second <= it.second;
        do
            @(posedge aclk);
        while (s_ready !== 1'b1);
        sb.accept_item(it);
    endtask

    // Drop valid, wait for every owed sample, then let the block settle.
    task automatic wait_idle();
        int guard;
        guard = 0;
        s_valid <= 1'b0;
        while (sb.pending_samples.size() != 0 && guard < DRAIN_LIMIT) begin
            @(posedge aclk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // APB write: setup cycle, then access cycle; pready is always high.
    task automatic write_reg(logic idx, logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 3'(int'(idx) * 4);
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
    endtask

    task automatic apply_config(logic [1:0] cc, logic [12:0] bb);
        write_reg(CFG_CHANNEL_COUNT, 32'(cc));
        write_reg(CFG_BLOCK_BYTES, 32'(bb));
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        sb.channel_count = cc;
        sb.block_bytes = bb;
        settings_used++;
    endtask

    task automatic run_phase(logic [1:0] cc, logic [12:0] bb, int tx_pct, int rx_pct,
                             int count, bit hold);
        wait_idle();
        apply_config(cc, bb);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        if (hold)
            rx_hold_armed = 1'b1;
        repeat (count) send_item(random_item());
    endtask

    initial begin
        sb = new();
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_action <= 1'b0;
        s_data_byte <= '0;
        s_coef_index <= '0;
        s_coef_first <= '0;
        s_coef_second <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part, mono with an eight-byte block: one data byte per block.
        apply_config(2'd1, 13'd8);
        tx_idle_pct = TX_BUSY_PCT;
        rx_idle_pct = RX_BUSY_PCT;
        // Extreme weights in the spare entry, then a header that selects it with
        // the largest step and extreme samples; the data byte saturates both.
        send_item(load(3'd7, 16'sh8000, 16'sh7FFF));
        send_item(feed(8'd7));
        send_item(feed(8'hFF));
        send_item(feed(8'h7F));
        send_item(feed(8'hFF));
        send_item(feed(8'h7F));
        send_item(feed(8'h00));
        send_item(feed(8'h80));
        send_item(feed(8'h7F));
        // Out-of-range predictor byte and a negative step; the table entry in use
        // is reloaded in the middle of the block before the data byte.
        send_item(feed(8'd200));
        send_item(feed(8'hF0));
        send_item(feed(8'hFF));
        send_item(feed(8'h00));
        send_item(feed(8'h00));
        send_item(feed(8'h00));
        send_item(feed(8'h00));
        send_item(load(3'd0, 16'sh7FFF, 16'sh8000));
        send_item(feed(8'h80));
        // Put the disturbed entries back to sane weights.
        send_item(load(3'd0, 16'sd256, 16'sd0));
        send_item(load(3'd7, 16'sd128, 16'sd64));

        // Random part. Settings change mid-block, so a shrinking block length
        // also lands the position past the new end.
        run_phase(2'd2, 13'd30,   TX_BUSY_PCT, RX_BUSY_PCT, 70, 1'b0);
        run_phase(2'd1, 13'd8,    TX_BUSY_PCT, RX_BUSY_PCT, 60, 1'b0);
        run_phase(2'd0, 13'd0,    TX_BUSY_PCT, RX_BUSY_PCT, 40, 1'b0);
        run_phase(2'd3, 13'd4096, RX_BUSY_PCT, TX_BUSY_PCT, 80, 1'b0);
        run_phase(2'd1, 13'd20,   RX_BUSY_PCT, TX_BUSY_PCT, 60, 1'b0);
        run_phase(2'd2, 13'd8191, RX_BUSY_PCT, TX_BUSY_PCT, 40, 1'b0);
        run_phase(2'd2, 13'd64,   0,           0,           90, 1'b1);
        run_phase(2'd1, 13'd1024, 0,           0,           60, 1'b0);

        wait_idle();
        if (sb.pending_samples.size() != 0) begin
            $error("%0d expected samples never arrived", sb.pending_samples.size());
            sb.error_count++;
        end
        $display("tb: fed %0d stream bytes and %0d table loads under %0d register settings",
                 sb.bytes_fed, sb.loads_fed, settings_used);
        $display("tb: compared %0d decoded samples, %0d errors",
                 sb.samples_checked, sb.error_count);
        if (sb.error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #(TIMEOUT_NS);
        $display("tb: failure");
        $finish;
    end

endmodule
